[rtl/core/hbm_pkg.sv]
// Shared types, codes and constants of the heartbeat timeout monitor.
package hbm_pkg;

	localparam int DEFAULT_CHANNELS = 16;

	localparam int CH_W     = 4;
	localparam int CH_CMP_W = 7;
	localparam int MASK_W   = 16;
	localparam int WIDE_W   = 64;
	localparam int LEVEL_W  = 8;
	localparam int TIME_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] CMD_EVALUATE  = 2'd0;
	localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
	localparam logic [1:0] CMD_CONFIGURE = 2'd2;

	localparam logic [1:0] LED_KEEP   = 2'd0;
	localparam logic [1:0] LED_GREEN  = 2'd1;
	localparam logic [1:0] LED_YELLOW = 2'd2;
	localparam logic [1:0] LED_RED    = 2'd3;

	localparam logic [LEVEL_W-1:0] NO_LEVEL = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LEVEL = 1'd1;

	localparam logic [LEVEL_W-1:0] RED_LEVEL_RESET     = 8'd0;
	localparam logic [LEVEL_W-1:0] WARNING_LEVEL_RESET = 8'd1;

	typedef struct packed {
		logic [1:0]         command;
		logic [CH_W-1:0]    channel;
		logic [TIME_W-1:0]  time_ms;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  timeout_ms;
		logic [7:0]         beep_request;
	} hbm_cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]   alert_channel;
		logic [1:0]        led_color;
		logic [7:0]        beep_count;
		logic [MASK_W-1:0] offline_mask;
	} hbm_rpt_t;

	typedef struct packed {
		logic [TIME_W-1:0]  timeout;
		logic [LEVEL_W-1:0] severity;
		logic [7:0]         beeps;
	} hbm_chan_rec_t;

endpackage

[rtl/core/hbm_stream_if.sv]
// Valid/ready stream interface that carries one payload beat.
interface hbm_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/hbm_chan_mem.sv]
// Per-channel storage: last-seen time stamps and channel configuration records.
module hbm_chan_mem import hbm_pkg::*; #(
	parameter int CHANNELS = DEFAULT_CHANNELS,
	localparam int IDX_W = $clog2(CHANNELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic              seen_we,
	input  logic [TIME_W-1:0] seen_wdata,
	input  logic              cfg_we,
	input  hbm_chan_rec_t     cfg_wdata,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [TIME_W-1:0] seen_rdata,
	output hbm_chan_rec_t     cfg_rdata
);

	logic [TIME_W-1:0] seen_mem [CHANNELS];
	hbm_chan_rec_t     cfg_mem [CHANNELS];

	logic [TIME_W-1:0] seen_rd_q;
	hbm_chan_rec_t     cfg_rd_q;
	logic [CHANNELS-1:0] seen_vld_q;
	logic              seen_rd_vld_q;

	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[wr_addr] <= seen_wdata;
		end
		if (cfg_we) begin
			cfg_mem[wr_addr] <= cfg_wdata;
		end
		if (rd_en) begin
			seen_rd_q <= seen_mem[rd_addr];
			cfg_rd_q  <= cfg_mem[rd_addr];
		end
	end

	// A stamp never written reads as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_vld_q    <= '0;
			seen_rd_vld_q <= 1'b0;
		end else begin
			if (seen_we) begin
				seen_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				seen_rd_vld_q <= seen_vld_q[rd_addr];
			end
		end
	end

	assign seen_rdata = seen_rd_vld_q ? seen_rd_q : '0;
	assign cfg_rdata  = cfg_rd_q;

endmodule

[rtl/core/hbm_ctrl.sv]
// Command decode, channel scan sequencer and offline selection.
module hbm_ctrl import hbm_pkg::*; #(
	parameter int CHANNELS = DEFAULT_CHANNELS,
	localparam int IDX_W = $clog2(CHANNELS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  hbm_cmd_t           in_data,
	output logic               in_ready,
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] warning_level,
	output logic               res_valid,
	output hbm_rpt_t           res,
	input  logic               res_take,
	output logic [IDX_W-1:0]   wr_addr,
	output logic               seen_we,
	output logic [TIME_W-1:0]  seen_wdata,
	output logic               cfg_we,
	output hbm_chan_rec_t      cfg_wdata,
	output logic               rd_en,
	output logic [IDX_W-1:0]   rd_addr,
	input  logic [TIME_W-1:0]  seen_rdata,
	input  hbm_chan_rec_t      cfg_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CHANNELS - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [TIME_W-1:0]   now_q;
	logic [CHANNELS-1:0] enabled_q;
	logic [CHANNELS-1:0] offline_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [IDX_W-1:0]    best_ch_q;
	logic [LEVEL_W-1:0]  best_lvl_q;
	logic [7:0]          best_beep_q;

	logic                accept;
	logic                ch_ok;
	logic [CH_CMP_W-1:0] ch_wide;
	logic [TIME_W-1:0]   elapsed;
	logic                hit;
	logic [CH_CMP_W-1:0] best_wide;
	logic [WIDE_W-1:0]   off_wide;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign ch_wide  = CH_CMP_W'(in_data.channel);
	assign ch_ok    = ch_wide < CH_CMP_W'(CHANNELS);

	assign wr_addr    = IDX_W'(ch_wide);
	assign seen_we    = accept && (in_data.command == CMD_HEARTBEAT) && ch_ok;
	assign seen_wdata = in_data.time_ms;
	assign cfg_we     = accept && (in_data.command == CMD_CONFIGURE) && ch_ok;
	assign cfg_wdata  = '{timeout: in_data.timeout_ms, severity: in_data.level,
		beeps: in_data.beep_request};

	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = idx_q;

	// Wrapping difference, so a time counter rollover still measures silence.
	assign elapsed = now_q - seen_rdata;
	assign hit     = enabled_q[idx_s1] && (elapsed > cfg_rdata.timeout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= FIRST_IDX;
			now_q       <= '0;
			enabled_q   <= '0;
			offline_q   <= '0;
			rd_vld_s1   <= 1'b0;
			idx_s1      <= '0;
			best_ch_q   <= '0;
			best_lvl_q  <= NO_LEVEL;
			best_beep_q <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			idx_s1    <= idx_q;

			if (cfg_we) begin
				enabled_q[wr_addr] <= 1'b1;
				offline_q[wr_addr] <= 1'b1;
			end

			if (rd_vld_s1) begin
				offline_q[idx_s1] <= hit;
				if (hit && (cfg_rdata.severity < best_lvl_q)) begin
					best_ch_q   <= idx_s1;
					best_lvl_q  <= cfg_rdata.severity;
					best_beep_q <= cfg_rdata.beeps;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_data.command == CMD_EVALUATE)) begin
						now_q      <= in_data.time_ms;
						idx_q      <= FIRST_IDX;
						best_ch_q  <= '0;
						best_lvl_q <= NO_LEVEL;
						best_beep_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= IDX_W'(idx_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign best_wide = CH_CMP_W'(best_ch_q);
	assign off_wide  = WIDE_W'(offline_q);

	always_comb begin
		res.alert_channel = best_wide[CH_W-1:0];
		res.offline_mask  = off_wide[MASK_W-1:0] & ~MASK_W'(1);
		res.beep_count    = '0;
		res.led_color     = LED_GREEN;
		if (best_ch_q != '0) begin
			res.beep_count = best_beep_q;
			priority if (best_lvl_q == red_level) begin
				res.led_color = LED_RED;
			end else if (best_lvl_q == warning_level) begin
				res.led_color = LED_YELLOW;
			end else begin
				res.led_color = LED_KEEP;
			end
		end
	end

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("scan read data arrived outside a scan");

	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_we || cfg_we) |-> (state_q == ST_IDLE))
		else $error("memory write during a scan");

	a_best_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		(best_ch_q != '0) |-> (best_lvl_q != NO_LEVEL))
		else $error("chosen channel carries the never-chosen severity");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q == LAST_IDX) |=> (state_q == ST_DRAIN))
		else $error("scan did not stop at the last channel");

endmodule

[rtl/core/heartbeat_timeout_monitor.sv]
// Top level of the multi-channel heartbeat timeout monitor.
//
// Usage: commands arrive as beats on the cmd stream (valid/ready). A configure
// beat enables a channel and stores its severity, timeout and beep count; a
// heartbeat beat stamps the channel's last-seen time with time_ms. Neither
// produces a report. An evaluate beat starts a scan of channels 1 to
// CHANNELS-1 and yields exactly one report beat on the rpt stream.
//
// Flow control: heartbeat and configure are taken one per cycle while the
// block is idle. An evaluate reads one channel per cycle from the channel
// memories through their single read port, then passes the drain and done
// states; it holds off new commands until the output register takes its
// report.
//
// Reset makes each last-seen stamp read as zero, disables all channels and
// restores the level codes (red 0, warning 1). A stalled report waits in the
// output register while the next command is accepted; a second one waits in the
// scanner until that register frees up. The block does not check that the user
// writes level codes on cfg_we/cfg_index/cfg_data only while the block is idle.
module heartbeat_timeout_monitor import hbm_pkg::*; #(
	parameter int CHANNELS = DEFAULT_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hbm_stream_if.sink           cmd,
	hbm_stream_if.source         rpt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(CHANNELS);

	logic [LEVEL_W-1:0] red_level_q;
	logic [LEVEL_W-1:0] warning_level_q;
	logic               out_vld_q;
	hbm_rpt_t           out_q;

	logic               res_valid;
	hbm_rpt_t           res;
	logic               res_take;
	logic [IDX_W-1:0]   wr_addr;
	logic               seen_we;
	logic [TIME_W-1:0]  seen_wdata;
	logic               cfg_wr;
	hbm_chan_rec_t      cfg_wdata;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [TIME_W-1:0]  seen_rdata;
	hbm_chan_rec_t      cfg_rdata;
	hbm_cmd_t           cmd_data;

	assign cmd_data = cmd.data;

	// Severity codes that map the chosen channel to a red or yellow LED.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_level_q     <= RED_LEVEL_RESET;
			warning_level_q <= WARNING_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RED_LEVEL:     red_level_q     <= cfg_data;
				CFG_WARNING_LEVEL: warning_level_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hbm_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (cmd.valid),
		.in_data       (cmd_data),
		.in_ready      (cmd.ready),
		.red_level     (red_level_q),
		.warning_level (warning_level_q),
		.res_valid     (res_valid),
		.res           (res),
		.res_take      (res_take),
		.wr_addr       (wr_addr),
		.seen_we       (seen_we),
		.seen_wdata    (seen_wdata),
		.cfg_we        (cfg_wr),
		.cfg_wdata     (cfg_wdata),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.seen_rdata    (seen_rdata),
		.cfg_rdata     (cfg_rdata)
	);

	hbm_chan_mem #(
		.CHANNELS (CHANNELS)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_addr    (wr_addr),
		.seen_we    (seen_we),
		.seen_wdata (seen_wdata),
		.cfg_we     (cfg_wr),
		.cfg_wdata  (cfg_wdata),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.seen_rdata (seen_rdata),
		.cfg_rdata  (cfg_rdata)
	);

	// The output register decouples the report from the scanner; it reloads
	// in the same cycle that the receiver takes the previous beat.
	assign res_take = res_valid && (!out_vld_q || rpt.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (rpt.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rpt.valid = out_vld_q;
	assign rpt.data  = out_q;

endmodule

[verif/heartbeat_timeout_monitor_tb.sv]
// Self-checking testbench for the heartbeat timeout monitor: directed and random command beats.
module heartbeat_timeout_monitor_tb import hbm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = DEFAULT_CHANNELS;

	// The command field has one code that the block must ignore.
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	// This margin outlasts the scan of an evaluate and also covers the report hand-off.
	localparam int SETTLE_CYCLES = NUM_CH + 4;

	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEVEL_W-1:0]   cfg_data;

	hbm_stream_if #(.T(hbm_cmd_t)) cmd_if ();
	hbm_stream_if #(.T(hbm_rpt_t)) rpt_if ();

	heartbeat_timeout_monitor #(
		.CHANNELS(NUM_CH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rpt(rpt_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the monitor's channel tables and level codes.
	logic [TIME_W-1:0]  seen_ms [NUM_CH];
	logic [TIME_W-1:0]  limit_ms [NUM_CH];
	logic [LEVEL_W-1:0] severity [NUM_CH];
	logic [7:0]         beeps [NUM_CH];
	logic [NUM_CH-1:0]  enabled;
	logic [NUM_CH-1:0]  offline;
	logic [LEVEL_W-1:0] error_code;
	logic [LEVEL_W-1:0] warning_code;

	// Reports predicted for accepted evaluate beats, oldest first.
	hbm_rpt_t pending_reports [$];

	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Running millisecond clock used to build plausible time stamps.
	logic [TIME_W-1:0] now_ms = '0;

	// Applies one accepted command to the shadow state. Only an evaluate produces
	// a report; it scans channels 1 and up, marks each one offline or online, and
	// picks the offline channel of lowest severity below 255, lowest index on a tie.
	function automatic void apply_cmd(input hbm_cmd_t c, output bit produced,
			output hbm_rpt_t r);
		logic [TIME_W-1:0]  elapsed;
		logic [CH_W-1:0]    best_ch;
		logic [LEVEL_W-1:0] best_lvl;
		logic [15:0]        mask;
		int                 i;
		produced = 1'b0;
		r = '0;
		case (c.command)
			CMD_HEARTBEAT: begin
				seen_ms[c.channel] = c.time_ms;
			end
			CMD_CONFIGURE: begin
				enabled[c.channel] = 1'b1;
				offline[c.channel] = 1'b1;
				severity[c.channel] = c.level;
				limit_ms[c.channel] = c.timeout_ms;
				beeps[c.channel] = c.beep_request;
			end
			CMD_EVALUATE: begin
				best_ch = '0;
				best_lvl = NO_LEVEL;
				for (i = 1; i < NUM_CH; i++) begin
					elapsed = c.time_ms - seen_ms[i];
					if (enabled[i] && elapsed > limit_ms[i]) begin
						offline[i] = 1'b1;
						if (severity[i] < best_lvl) begin
							best_lvl = severity[i];
							best_ch = CH_W'(i);
						end
					end else begin
						offline[i] = 1'b0;
					end
				end
				mask = 16'(offline);
				r.offline_mask = mask & 16'hFFFE;
				r.alert_channel = best_ch;
				if (best_ch != '0) begin
					r.beep_count = beeps[best_ch];
					// Red wins when both codes hold the same value.
					if (best_lvl == error_code)
						r.led_color = LED_RED;
					else if (best_lvl == warning_code)
						r.led_color = LED_YELLOW;
					else
						r.led_color = LED_KEEP;
				end else begin
					r.beep_count = '0;
					r.led_color = LED_GREEN;
				end
				produced = 1'b1;
			end
			default: begin
				// The reserved code changes nothing.
			end
		endcase
	endfunction

	function automatic hbm_cmd_t make_cmd(input logic [1:0] op, input int ch,
			input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lvl,
			input logic [TIME_W-1:0] tmo, input logic [7:0] beep);
		hbm_cmd_t c;
		c.command = op;
		c.channel = CH_W'(ch);
		c.time_ms = t;
		c.level = lvl;
		c.timeout_ms = tmo;
		c.beep_request = beep;
		return c;
	endfunction

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Beat monitor. Report beats are compared against the oldest prediction;
	// command beats update the shadow state and may queue a new prediction.
	always @(posedge clk) begin
		hbm_rpt_t want;
		hbm_rpt_t got;
		hbm_rpt_t predicted;
		bit       produced;
		if (arst_n) begin
			if (rpt_if.valid && rpt_if.ready) begin
				got = rpt_if.data;
				if (pending_reports.size() == 0) begin
					$display("%0t: report beat with none expected: got %h", $time, got);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (got.alert_channel !== want.alert_channel) begin
						$display("%0t: alert_channel expected %0d got %0d", $time,
							want.alert_channel, got.alert_channel);
						mismatches++;
					end
					if (got.led_color !== want.led_color) begin
						$display("%0t: led_color expected %0d got %0d", $time,
							want.led_color, got.led_color);
						mismatches++;
					end
					if (got.beep_count !== want.beep_count) begin
						$display("%0t: beep_count expected %0d got %0d", $time,
							want.beep_count, got.beep_count);
						mismatches++;
					end
					if (got.offline_mask !== want.offline_mask) begin
						$display("%0t: offline_mask expected %h got %h", $time,
							want.offline_mask, got.offline_mask);
						mismatches++;
					end
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				apply_cmd(cmd_if.data, produced, predicted);
				if (produced)
					pending_reports.push_back(predicted);
			end
		end
	end

	// Report receiver: ready is redrawn every falling edge from the stall rate.
	initial begin
		rpt_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rpt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Sends one command beat. Entered and left at a falling edge; valid stays
	// high on exit so back-to-back beats need no extra assignment.
	task automatic send_cmd(input hbm_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data <= c;
		do @(posedge clk); while (!cmd_if.ready);
		@(negedge clk);
	endtask

	// Waits until every predicted report has arrived and the block has had
	// time to finish any command that produces no report.
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_codes(input logic [LEVEL_W-1:0] err, input logic [LEVEL_W-1:0] warn);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_RED_LEVEL;
		cfg_data <= err;
		@(negedge clk);
		cfg_index <= CFG_WARNING_LEVEL;
		cfg_data <= warn;
		@(negedge clk);
		cfg_we <= 1'b0;
		error_code = err;
		warning_code = warn;
		@(negedge clk);
	endtask

	// Right after reset nothing is enabled, so the scan reports all online.
	// Channel 0 accepts writes but must never show up in a report.
	task automatic test_power_on();
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'd0, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_CONFIGURE, 0, 32'd0, 8'd0, 32'd0, 8'hFF));
		send_cmd(make_cmd(CMD_HEARTBEAT, 0, 32'hFFFF_FFFF, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'hFFFF_FFFF, 8'd0, 32'd0, 8'd0));
	endtask

	// Timeout comparison across the counter wrap, severity ties, the
	// never-chosen severity, the full-range timeout and the reserved command.
	task automatic test_timeout_rules();
		send_cmd(make_cmd(CMD_CONFIGURE, 15, 32'd0, NO_LEVEL, 32'd0, 8'hFF));
		send_cmd(make_cmd(CMD_CONFIGURE, 1, 32'd0, 8'd0, 32'hFFFF_FFFF, 8'd0));
		send_cmd(make_cmd(CMD_CONFIGURE, 7, 32'd0, 8'd1, 32'd10, 8'd5));
		send_cmd(make_cmd(CMD_CONFIGURE, 9, 32'd0, 8'd1, 32'd10, 8'd9));
		send_cmd(make_cmd(CMD_HEARTBEAT, 7, 32'hFFFF_FFF0, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_HEARTBEAT, 9, 32'hFFFF_FFF0, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_HEARTBEAT, 15, 32'd0, 8'd0, 32'd0, 8'd0));
		// The wrapped silence of 21 exceeds 10 on both tied channels.
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'd5, 8'd0, 32'd0, 8'd0));
		// Now only the severity-255 channel is offline, so nothing is chosen.
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'hFFFF_FFF5, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_RESERVED, 3, 32'hA5A5_5A5A, 8'hAA, 32'h5555_AAAA, 8'h55));
		send_cmd(make_cmd(CMD_CONFIGURE, 3, 32'd0, 8'd0, 32'd0, 8'd200));
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'd1, 8'd0, 32'd0, 8'd0));
		// Exactly at the timeout the channel still counts as online.
		send_cmd(make_cmd(CMD_HEARTBEAT, 3, 32'd100, 8'd0, 32'd0, 8'd0));
		send_cmd(make_cmd(CMD_EVALUATE, 0, 32'd100, 8'd0, 32'd0, 8'd0));
	endtask

	// Each code setting is checked against a channel whose severity matches
	// the error code, the warning code, or neither.
	task automatic test_level_codes();
		logic [LEVEL_W-1:0] err_set [4] = '{8'd0, 8'd255, 8'd128, 8'd200};
		logic [LEVEL_W-1:0] warn_set [4] = '{8'd255, 8'd0, 8'd128, 8'd201};
		logic [LEVEL_W-1:0] lvl;
		int                 s;
		int                 k;
		int                 ch;
		// Park channels 1 and up with a timeout that can never be exceeded.
		for (ch = 1; ch < NUM_CH; ch++)
			send_cmd(make_cmd(CMD_CONFIGURE, ch, 32'd0, NO_LEVEL, 32'hFFFF_FFFF, 8'd0));
		for (s = 0; s < 4; s++) begin
			write_codes(err_set[s], warn_set[s]);
			for (k = 0; k < 3; k++) begin
				lvl = (k == 0) ? err_set[s] : (k == 1) ? warn_set[s] : 8'd100;
				send_cmd(make_cmd(CMD_CONFIGURE, 5, 32'd0, lvl, 32'd0, 8'($urandom)));
				send_cmd(make_cmd(CMD_EVALUATE, 0, 32'd1 + k, 8'd0, 32'd0, 8'd0));
			end
		end
	endtask

	// Mostly plausible traffic: time moves forward in small steps with the
	// odd jump, timeouts are short so channels drift offline and back, and
	// severities often hit the programmed codes. A few reserved beats mix in.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		hbm_cmd_t           c;
		logic [LEVEL_W-1:0] err;
		int                 pick;
		int                 sent;
		err = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
		write_codes(err, ($urandom_range(3) == 0) ? err : 8'($urandom));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(19) == 0)
				now_ms = $urandom;
			else
				now_ms = now_ms + $urandom_range(20);
			c.time_ms = now_ms;
			c.channel = CH_W'($urandom_range(NUM_CH - 1));
			case ($urandom_range(7))
				0: c.level = 8'd0;
				1: c.level = error_code;
				2: c.level = warning_code;
				3: c.level = NO_LEVEL;
				default: c.level = 8'($urandom);
			endcase
			c.timeout_ms = ($urandom_range(5) == 0) ? TIME_W'($urandom) :
				TIME_W'($urandom_range(40));
			c.beep_request = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 35)
				c.command = CMD_EVALUATE;
			else if (pick < 70)
				c.command = CMD_HEARTBEAT;
			else if (pick < 95)
				c.command = CMD_CONFIGURE;
			else
				c.command = CMD_RESERVED;
			send_cmd(c);
			if (c.command != CMD_RESERVED)
				sent++;
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NUM_CH; i++) begin
			seen_ms[i] = '0;
			limit_ms[i] = '0;
			severity[i] = '0;
			beeps[i] = '0;
		end
		enabled = '0;
		offline = '0;
		error_code = RED_LEVEL_RESET;
		warning_code = WARNING_LEVEL_RESET;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RED_LEVEL;
		cfg_data = '0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_power_on();
		test_timeout_rules();
		test_level_codes();
		test_random_traffic(0, 0, 90);
		test_random_traffic(52, 0, 90);
		test_random_traffic(0, 52, 90);
		test_random_traffic(25, 25, 100);

		// Drain: every prediction must be met, and nothing may trail behind.
		cmd_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[heartbeat_timeout_monitor.f]
rtl/core/hbm_pkg.sv
rtl/core/hbm_stream_if.sv
rtl/core/hbm_chan_mem.sv
rtl/core/hbm_ctrl.sv
rtl/core/heartbeat_timeout_monitor.sv
verif/heartbeat_timeout_monitor_tb.sv
